[rtl/u8dec_pkg.sv]
package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned LEN_W  = 3;

  // result status codes
  localparam logic [ST_W-1:0] ST_CHAR    = 2'd0;
  localparam logic [ST_W-1:0] ST_END     = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
  localparam logic [ST_W-1:0] ST_TRUNC   = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [LEN_W-1:0]  len_t;

endpackage

[rtl/u8dec_ifs.sv]
// byte input channel
interface u8dec_byte_if;
  logic             valid;
  logic             ready;
  u8dec_pkg::byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// decoded result channel
interface u8dec_res_if;
  logic               valid;
  logic               ready;
  u8dec_pkg::cp_t     code_point;
  u8dec_pkg::status_t status;
  u8dec_pkg::count_t  char_count;
  logic               last;

  modport source (output valid, output code_point, output status, output char_count,
                  output last, input ready);
  modport sink   (input valid, input code_point, input status, input char_count,
                  input last, output ready);
endinterface

// configuration write channel
interface u8dec_cfg_if;
  logic valid;
  logic ready;
  logic raw_bytes;

  modport source (output valid, output raw_bytes, input ready);
  modport sink   (input valid, input raw_bytes, output ready);
endinterface

[rtl/utf8_code_point_decoder_core.sv]
// path: an accepted byte is held in the byte register, and its result (if any) goes into the output register
// throughput: one byte per cycle while the output is not stalled, set by the decode step on the byte register
// a byte is still taken while one result waits at the output (byte register acts as skid)
// reset: synchronous active-low rst_n clears the decode state, the char counter,
// raw_bytes and both valid flags; payload registers are not reset
module utf8_code_point_decoder_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  u8dec_byte_if.sink    in_if,
  u8dec_res_if.source   out_if,
  u8dec_cfg_if.sink     cfg_if
);

  // counter extended to at least the output width before truncation
  localparam int unsigned EXT_W = (COUNT_WIDTH > u8dec_pkg::CNT_W) ?
                                  COUNT_WIDTH : u8dec_pkg::CNT_W;

  // configuration
  logic raw_r;

  // byte register (input stage)
  logic             in_vld_r;
  u8dec_pkg::byte_t byte_r;

  // decode state
  u8dec_pkg::len_t  bl_r, bl_nxt;       // continuation bytes still expected
  u8dec_pkg::len_t  sl_r, sl_nxt;       // sequence length
  u8dec_pkg::cp_t   acc_r, acc_nxt;     // partial code point
  logic             bad_r, bad_nxt;     // bad continuation seen
  logic             disc_r, disc_nxt;   // dropping bytes until end of string
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  // output register
  logic               out_vld_r;
  u8dec_pkg::cp_t     out_cp_r;
  u8dec_pkg::status_t out_st_r;
  u8dec_pkg::count_t  out_cnt_r;
  logic               out_last_r;

  // decode results
  logic               adv;
  logic               emit;
  u8dec_pkg::cp_t     res_cp;
  u8dec_pkg::status_t res_st;
  logic               res_last;
  logic [COUNT_WIDTH-1:0] res_cnt;
  logic [COUNT_WIDTH-1:0] cnt_bump;
  logic [EXT_W-1:0]       res_cnt_ext;
  u8dec_pkg::cp_t     v_new;
  logic               cont_ok;
  logic               v_reject;

  // the byte register moves into decode when the output can take a result
  assign adv          = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready  = !in_vld_r || adv;
  assign cfg_if.ready = 1'b1;

  assign cnt_bump = (cnt_r == {COUNT_WIDTH{1'b1}}) ? cnt_r : cnt_r + COUNT_WIDTH'(1);

  // continuation step: shift in six payload bits
  assign v_new   = {acc_r[u8dec_pkg::CP_W-7:0], byte_r[5:0]};
  assign cont_ok = (byte_r[7:6] == 2'b10);
  // three-byte results that are surrogates or the two noncharacters
  assign v_reject = (sl_r == 3'd3) && (v_new[30:16] == 15'd0) &&
                    ((v_new[15:11] == 5'b11011) || (v_new[15:1] == 15'h7fff));

  always_comb begin
    bl_nxt   = bl_r;
    sl_nxt   = sl_r;
    acc_nxt  = acc_r;
    bad_nxt  = bad_r;
    disc_nxt = disc_r;
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    res_cp   = '0;
    res_st   = u8dec_pkg::ST_CHAR;
    res_last = 1'b0;
    res_cnt  = cnt_r;
    if (adv) begin
      if (raw_r) begin
        // raw mode: drop any sequence, pass nonzero bytes through, a zero byte ends the string
        bl_nxt   = '0;
        sl_nxt   = '0;
        acc_nxt  = '0;
        bad_nxt  = 1'b0;
        disc_nxt = 1'b0;
        emit     = 1'b1;
        if (byte_r == '0) begin
          res_st   = u8dec_pkg::ST_END;
          res_last = 1'b1;
          cnt_nxt  = '0;
        end else begin
          res_cp  = u8dec_pkg::CP_W'(byte_r);
          cnt_nxt = cnt_bump;
          res_cnt = cnt_bump;
        end
      end else if (disc_r) begin
        // skip the rest of the string after an invalid result
        if (byte_r == '0) begin
          disc_nxt = 1'b0;
          cnt_nxt  = '0;
        end
      end else if (bl_r == '0) begin
        // between characters: lead byte
        priority if (byte_r == '0) begin
          emit     = 1'b1;
          res_st   = u8dec_pkg::ST_END;
          res_last = 1'b1;
          cnt_nxt  = '0;
        end else if (byte_r < 8'hc0) begin
          emit    = 1'b1;
          res_cp  = u8dec_pkg::CP_W'(byte_r);
          cnt_nxt = cnt_bump;
          res_cnt = cnt_bump;
        end else begin
          bad_nxt = 1'b0;
          priority if (byte_r < 8'he0) begin
            sl_nxt  = 3'd2;
            acc_nxt = u8dec_pkg::CP_W'(byte_r[4:0]);
          end else if (byte_r < 8'hf0) begin
            sl_nxt  = 3'd3;
            acc_nxt = u8dec_pkg::CP_W'(byte_r[3:0]);
          end else if (byte_r < 8'hf8) begin
            sl_nxt  = 3'd4;
            acc_nxt = u8dec_pkg::CP_W'(byte_r[2:0]);
          end else if (byte_r < 8'hfc) begin
            sl_nxt  = 3'd5;
            acc_nxt = u8dec_pkg::CP_W'(byte_r[1:0]);
          end else begin
            sl_nxt  = 3'd6;
            acc_nxt = u8dec_pkg::CP_W'(byte_r[0]);
          end
          bl_nxt = sl_nxt - 3'd1;
        end
      end else if (byte_r == '0) begin
        // string ended inside a sequence
        bl_nxt   = '0;
        sl_nxt   = '0;
        acc_nxt  = '0;
        bad_nxt  = 1'b0;
        emit     = 1'b1;
        res_st   = u8dec_pkg::ST_TRUNC;
        res_last = 1'b1;
        cnt_nxt  = '0;
      end else if (bl_r != 3'd1) begin
        // more continuation bytes to come
        bad_nxt = bad_r | !cont_ok;
        acc_nxt = v_new;
        bl_nxt  = bl_r - 3'd1;
      end else begin
        // final continuation byte completes the character
        bl_nxt  = '0;
        sl_nxt  = '0;
        acc_nxt = '0;
        bad_nxt = 1'b0;
        emit    = 1'b1;
        if (bad_r || !cont_ok || v_reject) begin
          disc_nxt = 1'b1;
          res_st   = u8dec_pkg::ST_INVALID;
          res_last = 1'b1;
        end else begin
          res_cp  = v_new;
          cnt_nxt = cnt_bump;
          res_cnt = cnt_bump;
        end
      end
    end
  end

  assign res_cnt_ext = EXT_W'(res_cnt);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r     <= 1'b0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      bl_r      <= '0;
      sl_r      <= '0;
      acc_r     <= '0;
      bad_r     <= 1'b0;
      disc_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (cfg_if.valid) begin
        raw_r <= cfg_if.raw_bytes;
      end
      if (in_if.valid && in_if.ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv && emit) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
      bl_r   <= bl_nxt;
      sl_r   <= sl_nxt;
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
      disc_r <= disc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      byte_r <= in_if.in_byte;
    end
    if (adv && emit) begin
      out_cp_r   <= res_cp;
      out_st_r   <= res_st;
      out_cnt_r  <= res_cnt_ext[u8dec_pkg::CNT_W-1:0];
      out_last_r <= res_last;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.code_point = out_cp_r;
  assign out_if.status     = out_st_r;
  assign out_if.char_count = out_cnt_r;
  assign out_if.last       = out_last_r;

endmodule

[dv/u8dec_decode_checker.sv]
`timescale 1ns / 100ps

module u8dec_decode_checker #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  u8dec_byte_if       byte_ch,
  u8dec_res_if        res_ch,
  u8dec_cfg_if        cfg_ch,
  output int unsigned errors,
  output int unsigned outstanding
);

  typedef struct packed {
    u8dec_pkg::cp_t     code_point;
    u8dec_pkg::status_t status;
    u8dec_pkg::count_t  char_count;
    logic               last;
  } decoded_t;

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

  logic              raw_mode;
  u8dec_pkg::len_t   cont_left;
  u8dec_pkg::len_t   seq_len;
  u8dec_pkg::cp_t    accum;
  logic              bad_cont;
  logic              skipping;
  longint unsigned   chars_seen;
  decoded_t          decoded_q[$];

  function automatic void push_decoded(input u8dec_pkg::cp_t cp,
                                       input u8dec_pkg::status_t st, input logic lst);
    decoded_t d;
    d.code_point = cp;
    d.status     = st;
    d.char_count = u8dec_pkg::count_t'(chars_seen);
    d.last       = lst;
    decoded_q.push_back(d);
  endfunction

  function automatic void count_char();
    if (chars_seen < COUNT_MAX) chars_seen++;
  endfunction

  function automatic void clear_seq();
    cont_left = '0;
    seq_len   = '0;
    accum     = '0;
    bad_cont  = 1'b0;
  endfunction

  // one byte through the decoder state, queueing the result it causes
  function automatic void decode_byte(input u8dec_pkg::byte_t b);
    logic rejected;
    if (raw_mode) begin
      clear_seq();
      skipping = 1'b0;
      if (b == 8'h00) begin
        push_decoded('0, u8dec_pkg::ST_END, 1'b1);
        chars_seen = 0;
      end else begin
        count_char();
        push_decoded(u8dec_pkg::cp_t'(b), u8dec_pkg::ST_CHAR, 1'b0);
      end
    end else if (skipping) begin
      if (b == 8'h00) begin
        skipping   = 1'b0;
        chars_seen = 0;
      end
    end else if (cont_left == 0) begin
      if (b == 8'h00) begin
        push_decoded('0, u8dec_pkg::ST_END, 1'b1);
        chars_seen = 0;
      end else if (b < 8'hC0) begin
        count_char();
        push_decoded(u8dec_pkg::cp_t'(b), u8dec_pkg::ST_CHAR, 1'b0);
      end else begin
        bad_cont = 1'b0;
        if (b < 8'hE0) begin
          seq_len = 3'd2;
          accum   = u8dec_pkg::cp_t'(b[4:0]);
        end else if (b < 8'hF0) begin
          seq_len = 3'd3;
          accum   = u8dec_pkg::cp_t'(b[3:0]);
        end else if (b < 8'hF8) begin
          seq_len = 3'd4;
          accum   = u8dec_pkg::cp_t'(b[2:0]);
        end else if (b < 8'hFC) begin
          seq_len = 3'd5;
          accum   = u8dec_pkg::cp_t'(b[1:0]);
        end else begin
          seq_len = 3'd6;
          accum   = u8dec_pkg::cp_t'(b[0]);
        end
        cont_left = seq_len - 3'd1;
      end
    end else if (b == 8'h00) begin
      clear_seq();
      push_decoded('0, u8dec_pkg::ST_TRUNC, 1'b1);
      chars_seen = 0;
    end else begin
      if (b[7:6] != 2'b10) bad_cont = 1'b1;
      accum     = {accum[u8dec_pkg::CP_W-7:0], b[5:0]};
      cont_left = cont_left - 3'd1;
      if (cont_left == 0) begin
        rejected = bad_cont;
        // surrogates and the two noncharacters only matter in the three byte form
        if (seq_len == 3'd3 && ((accum >= 31'h0000D800 && accum <= 31'h0000DFFF) ||
            accum == 31'h0000FFFE || accum == 31'h0000FFFF))
          rejected = 1'b1;
        if (rejected) begin
          skipping = 1'b1;
          push_decoded('0, u8dec_pkg::ST_INVALID, 1'b1);
        end else begin
          count_char();
          push_decoded(accum, u8dec_pkg::ST_CHAR, 1'b0);
        end
        clear_seq();
      end
    end
  endfunction

  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      raw_mode   = 1'b0;
      skipping   = 1'b0;
      chars_seen = 0;
      clear_seq();
      decoded_q.delete();
    end else begin
      // results first: a byte taken at this edge cannot have its result out yet
      if (res_ch.valid && res_ch.ready) begin
        if (decoded_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result cp=%h st=%0d cnt=%0d last=%b", $realtime,
                     res_ch.code_point, res_ch.status, res_ch.char_count, res_ch.last);
        end else begin
          want = decoded_q.pop_front();
          if (res_ch.code_point !== want.code_point || res_ch.status !== want.status ||
              res_ch.char_count !== want.char_count || res_ch.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp cp=%h st=%0d cnt=%0d last=%b,",
                       $realtime, want.code_point, want.status, want.char_count, want.last,
                       " got cp=%h st=%0d cnt=%0d last=%b",
                       res_ch.code_point, res_ch.status, res_ch.char_count, res_ch.last);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) raw_mode = cfg_ch.raw_bytes;
      if (byte_ch.valid && byte_ch.ready) decode_byte(byte_ch.in_byte);
    end
    outstanding = decoded_q.size();
  end

endmodule

[dv/utf8_code_point_decoder_core_tb.sv]
`timescale 1ns / 100ps

module utf8_code_point_decoder_core_tb;

  localparam int unsigned COUNT_WIDTH = 16;
  // longest legal quiet stretch is a sender gap or a drain hold-off
  localparam int unsigned QUIET_LIMIT = 2000;

  logic clk;
  logic rst_n;

  u8dec_byte_if in_ch ();
  u8dec_res_if  out_ch ();
  u8dec_cfg_if  cfg_ch ();

  int unsigned errors;
  int unsigned outstanding;

  // sender and receiver pacing
  bit          no_idle;
  int unsigned burst_left;
  logic [7:0]  stall_pat;
  int unsigned pat_age;
  int unsigned quiet;

  utf8_code_point_decoder_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  u8dec_decode_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) decode_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_ch     (in_ch),
    .res_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: ready follows a rotating pattern, reloaded now and then
  // the pattern always has a set bit so every stall ends within one rotation of the pattern
  always @(negedge clk) begin
    if (pat_age == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      pat_age   = $urandom_range(16, 96);
    end
    out_ch.ready = no_idle ? 1'b1 : stall_pat[0];
    stall_pat    = {stall_pat[0], stall_pat[7:1]};
    pat_age--;
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  // valid stays high between bytes of a burst
  task automatic push_byte(input u8dec_pkg::byte_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_idle ? 0 : $urandom_range(0, 20);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic push_bytes(input u8dec_pkg::byte_t seq[$]);
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  // wait for every expected result, then let a byte with no result settle
  task automatic drain();
    in_ch.valid = 1'b0;
    burst_left  = 0;
    wait (outstanding == 0);
    repeat (6) @(negedge clk);
  endtask

  // raw_bytes is only written with the decoder idle
  task automatic set_raw(input logic mode);
    drain();
    cfg_ch.valid     = 1'b1;
    cfg_ch.raw_bytes = mode;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic u8dec_pkg::byte_t lead_for(input int unsigned len);
    case (len)
      2:       return u8dec_pkg::byte_t'($urandom_range(8'hC0, 8'hDF));
      3:       return u8dec_pkg::byte_t'($urandom_range(8'hE0, 8'hEF));
      4:       return u8dec_pkg::byte_t'($urandom_range(8'hF0, 8'hF7));
      5:       return u8dec_pkg::byte_t'($urandom_range(8'hF8, 8'hFB));
      default: return u8dec_pkg::byte_t'($urandom_range(8'hFC, 8'hFF));
    endcase
  endfunction

  // nonzero byte whose top bits are not 10
  function automatic u8dec_pkg::byte_t off_cont();
    if ($urandom_range(0, 1) == 0) return u8dec_pkg::byte_t'($urandom_range(1, 127));
    return u8dec_pkg::byte_t'($urandom_range(192, 255));
  endfunction

  // multi-byte sequence with random payload, optionally with one bad continuation
  task automatic push_seq(input int unsigned len, input bit corrupt);
    int unsigned      bad_pos;
    u8dec_pkg::byte_t c;
    bad_pos = corrupt ? $urandom_range(1, len - 1) : 0;
    push_byte(lead_for(len));
    for (int i = 1; i < len; i++) begin
      c = 8'h80 | u8dec_pkg::byte_t'($urandom_range(0, 63));
      if (i == bad_pos) c = off_cont();
      push_byte(c);
    end
  endtask

  // three byte form around the surrogate block and the top noncharacters
  task automatic push_edge3();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0:       v = 16'hD800 + 16'($urandom_range(0, 16'h07FF));
      1:       v = 16'hFFFE;
      2:       v = 16'hFFFF;
      3:       v = 16'hD7FF;
      default: v = 16'hE000;
    endcase
    push_byte({4'hE, v[15:12]});
    push_byte({2'b10, v[11:6]});
    push_byte({2'b10, v[5:0]});
  endtask

  task automatic random_char();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      push_byte(u8dec_pkg::byte_t'($urandom_range(1, 127)));
    end else if (kind < 38) begin
      push_byte(u8dec_pkg::byte_t'($urandom_range(128, 191)));
    end else if (kind < 85) begin
      push_seq($urandom_range(2, 6), 1'b0);
    end else if (kind < 90) begin
      push_edge3();
    end else if (kind < 95) begin
      push_seq($urandom_range(2, 6), 1'b1);
    end else if (kind < 98) begin
      // truncated: the zero ends the string early
      len = $urandom_range(2, 6);
      push_byte(lead_for(len));
      repeat ($urandom_range(0, len - 2))
        push_byte(8'h80 | u8dec_pkg::byte_t'($urandom_range(0, 63)));
      push_byte(8'h00);
    end else begin
      push_byte(u8dec_pkg::byte_t'($urandom_range(1, 255)));
    end
  endtask

  task automatic random_string();
    int unsigned n_chars;
    n_chars = $urandom_range(0, 10);
    repeat (n_chars) random_char();
    push_byte(8'h00);
  endtask

  initial begin
    int unsigned mark;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.raw_bytes = 1'b0;
    no_idle          = 1'b0;
    burst_left       = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: ascii, passthrough leads, 2, 3, 4 and 6 byte forms up to the largest value
    set_raw(1'b0);
    push_bytes('{8'h41, 8'h7F, 8'h80, 8'hBF, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                 8'hBF, 8'h00});
    // surrogate is invalid, the rest of the string is skipped
    push_bytes('{8'hED, 8'hA0, 8'h80, 8'h41, 8'h00});
    // noncharacter, then a bad continuation, then a zero inside a sequence
    push_bytes('{8'hEF, 8'hBF, 8'hBE, 8'h00, 8'hC3, 8'h41, 8'h00, 8'hE2, 8'h82, 8'h00});
    // five byte form and an overlong two byte form are accepted
    push_bytes('{8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'hC0, 8'h80, 8'h00});
    // raw mode drops a half-done sequence
    push_bytes('{8'hE2, 8'h82});
    set_raw(1'b1);
    push_bytes('{8'hFF, 8'hC3, 8'h00});
    // raw mode also drops the skip after an invalid sequence
    set_raw(1'b0);
    push_bytes('{8'hED, 8'hBF, 8'hBF, 8'h41});
    set_raw(1'b1);
    push_bytes('{8'h41, 8'h00});

    // random phases, two of the six in raw mode, one with no idling at all
    for (int phase = 0; phase < 6; phase++) begin
      set_raw((phase == 1 || phase == 4) ? 1'b1 : 1'b0);
      no_idle = (phase == 3);
      mark = 0;
      while (mark < 64) begin
        random_string();
        mark += 8;
      end
    end

    no_idle = 1'b0;
    set_raw(1'b0);
    repeat (16) random_string();

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/u8dec_pkg.sv
rtl/u8dec_ifs.sv
rtl/utf8_code_point_decoder_core.sv
dv/u8dec_decode_checker.sv
dv/utf8_code_point_decoder_core_tb.sv
